// File: rtl/core/branch_target_predictor_ras_tc_top_defines.svh
// Assertion macros used by the branch target predictor top level.
`ifndef BRANCH_TARGET_PREDICTOR_RAS_TC_TOP_DEFINES_SVH
`define BRANCH_TARGET_PREDICTOR_RAS_TC_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BTP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("btp assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define BTP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("btp assertion failed");

`endif

// File: rtl/core/btp_pkg.sv
// Package: types, codes and default sizes of the branch target predictor.
`default_nettype none
package btp_pkg;
	localparam int unsigned BTB_ENTRIES_DEF      = 2048;
	localparam int unsigned TAG_BITS_DEF         = 8;
	localparam int unsigned STACK_DEPTH_DEF      = 2048;
	localparam int unsigned REPEAT_BITS_DEF      = 8;
	localparam int unsigned HISTORY_ENTRIES_DEF  = 2048;
	localparam int unsigned INDIRECT_ENTRIES_DEF = 2048;

	localparam logic [31:0] NO_TARGET = 32'hFFFF_FFFF;
	localparam logic [31:0] PC_STEP   = 32'd4;

	localparam logic MODE_PREDICT = 1'b0;
	localparam logic MODE_UPDATE  = 1'b1;

	localparam logic [1:0] KIND_DIRECT   = 2'd0;
	localparam logic [1:0] KIND_CALL     = 2'd1;
	localparam logic [1:0] KIND_RETURN   = 2'd2;
	localparam logic [1:0] KIND_INDIRECT = 2'd3;

	typedef struct packed {
		logic        mode;
		logic [31:0] pc;
		logic [31:0] actual_target;
		logic [1:0]  branch_kind;
		logic        taken;
	} item_t;

	typedef struct packed {
		logic        target_valid;
		logic [31:0] target;
	} result_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic resolve;
		logic ind_done;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic need_ind;
	} ctl_sts_t;
endpackage
`default_nettype wire

// File: rtl/core/branch_target_predictor_ras_tc_top.sv
// Top level of the branch target predictor with return stack and indirect cache.
//
// Raise start with an item while busy is low; the item is taken at that edge.
// A predict item (mode 0) looks up a direct-mapped branch target buffer and,
// by the stored kind, gives the stored target, pushes pc+4 on the return stack
// (call), pops it (return), or reads the indirect target cache at history XOR
// pc. An update item (mode 1) writes the buffer and, for indirect branches,
// the target cache and the per-pc history. Every item gives exactly one result,
// shown on result for one cycle with result_valid high; the receiver cannot
// stall it, so capture it on that cycle. At capture the block reads the buffer,
// the return stack top and the history RAM; the indirect cache read depends on
// the history word, so a predict that hits an indirect entry adds an indirect step.
// busy is high from acceptance until the result shows, so items are handled
// one at a time. After reset a clearing sweep zeroes all tables, one address
// per cycle, over as many addresses as the largest table has entries (2048
// with default sizes); busy stays high during it. Table sizes must be powers
// of two.
`default_nettype none
`include "branch_target_predictor_ras_tc_top_defines.svh"
module branch_target_predictor_ras_tc_top #(
	parameter int unsigned BTB_ENTRIES      = btp_pkg::BTB_ENTRIES_DEF,
	parameter int unsigned TAG_BITS         = btp_pkg::TAG_BITS_DEF,
	parameter int unsigned STACK_DEPTH      = btp_pkg::STACK_DEPTH_DEF,
	parameter int unsigned REPEAT_BITS      = btp_pkg::REPEAT_BITS_DEF,
	parameter int unsigned HISTORY_ENTRIES  = btp_pkg::HISTORY_ENTRIES_DEF,
	parameter int unsigned INDIRECT_ENTRIES = btp_pkg::INDIRECT_ENTRIES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire btp_pkg::item_t   item,
	output      logic             busy,
	output      btp_pkg::result_t result,
	output      logic             result_valid
);
	btp_pkg::ctl_cmd_t cmd;
	btp_pkg::ctl_sts_t sts;

	// Sequence the clearing sweep and each item's steps.
	btp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.sts(sts), .cmd(cmd), .busy(busy));

	// Hold the tables and form the result.
	btp_dp #(
		.BTB_ENTRIES(BTB_ENTRIES), .TAG_BITS(TAG_BITS),
		.STACK_DEPTH(STACK_DEPTH), .REPEAT_BITS(REPEAT_BITS),
		.HISTORY_ENTRIES(HISTORY_ENTRIES), .INDIRECT_ENTRIES(INDIRECT_ENTRIES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .cmd(cmd), .sts(sts),
		.result(result), .result_valid(result_valid));

	// A result shows only once the block is free again.
	`BTP_ASSERT_NOW(a_result_idle, result_valid, !busy)
	// An accepted item keeps the block busy for the next cycle.
	`BTP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// An invalid result carries the all-ones target.
	`BTP_ASSERT_NOW(a_no_target, result_valid && !result.target_valid,
		result.target == btp_pkg::NO_TARGET)
endmodule
`default_nettype wire

// File: rtl/core/btp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module btp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/btp_ctrl.sv
// Controller: sequences clearing, lookup and indirect read steps.
`default_nettype none
module btp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire btp_pkg::ctl_sts_t sts,
	output      btp_pkg::ctl_cmd_t cmd,
	output      logic              busy
);
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_LOOK  = 4'b0100,
		ST_IND   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.resolve = 1'b1;
				state_d     = sts.need_ind ? ST_IND : ST_IDLE;
			end
			ST_IND: begin
				cmd.ind_done = 1'b1;
				state_d      = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);
endmodule
`default_nettype wire

// File: rtl/core/btp_dp.sv
// Datapath: tables, return stack, history and indirect target cache.
`default_nettype none
module btp_dp #(
	parameter int unsigned BTB_ENTRIES      = btp_pkg::BTB_ENTRIES_DEF,
	parameter int unsigned TAG_BITS         = btp_pkg::TAG_BITS_DEF,
	parameter int unsigned STACK_DEPTH      = btp_pkg::STACK_DEPTH_DEF,
	parameter int unsigned REPEAT_BITS      = btp_pkg::REPEAT_BITS_DEF,
	parameter int unsigned HISTORY_ENTRIES  = btp_pkg::HISTORY_ENTRIES_DEF,
	parameter int unsigned INDIRECT_ENTRIES = btp_pkg::INDIRECT_ENTRIES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire btp_pkg::item_t    item,
	input  wire btp_pkg::ctl_cmd_t cmd,
	output      btp_pkg::ctl_sts_t sts,
	output      btp_pkg::result_t  result,
	output      logic              result_valid
);
	localparam int unsigned BI = $clog2(BTB_ENTRIES);
	localparam int unsigned SW = $clog2(STACK_DEPTH);
	localparam int unsigned HI = $clog2(HISTORY_ENTRIES);
	localparam int unsigned IW = $clog2(INDIRECT_ENTRIES);
	localparam int unsigned BW = 3 + TAG_BITS + 32;
	localparam int unsigned KW = 32 + REPEAT_BITS;
	localparam int unsigned M1 = (BTB_ENTRIES > STACK_DEPTH) ? BTB_ENTRIES : STACK_DEPTH;
	localparam int unsigned M2 = (HISTORY_ENTRIES > INDIRECT_ENTRIES) ?
		HISTORY_ENTRIES : INDIRECT_ENTRIES;
	localparam int unsigned MAXD = (M1 > M2) ? M1 : M2;
	localparam int unsigned CW = $clog2(MAXD);

	btp_pkg::item_t   item_q;
	logic [CW-1:0]    clr_q;
	logic [SW-1:0]    sp_q;
	btp_pkg::result_t result_q;
	logic             result_valid_q;

	logic [BW-1:0] btb_rdata, btb_wdata;
	logic [KW-1:0] stk_rdata, stk_wdata;
	logic [IW-1:0] hist_rdata, hist_wdata;
	logic [31:0]   ind_rdata, ind_wdata;
	logic [BI-1:0] btb_waddr;
	logic [SW-1:0] stk_waddr;
	logic [HI-1:0] hist_waddr;
	logic [IW-1:0] ind_waddr, cix;
	logic btb_we, stk_we, hist_we, ind_we;

	logic                   e_valid;
	logic [TAG_BITS-1:0]    e_tag;
	logic [31:0]            e_target;
	logic [1:0]             e_kind;
	logic [31:0]            top_addr, pc4;
	logic [REPEAT_BITS-1:0] top_cnt, cnt_inc;
	logic hit, is_upd, upd_ind, call, ret, same, pop_ok;

	assign {e_valid, e_tag, e_target, e_kind} = btb_rdata;
	assign {top_addr, top_cnt} = stk_rdata;
	assign pc4     = item_q.pc + btp_pkg::PC_STEP;
	assign is_upd  = (item_q.mode == btp_pkg::MODE_UPDATE);
	assign upd_ind = is_upd && (item_q.branch_kind == btp_pkg::KIND_INDIRECT);
	assign hit     = !is_upd && e_valid && (e_tag == item_q.pc[TAG_BITS-1:0]);
	assign call    = cmd.resolve && hit && (e_kind == btp_pkg::KIND_CALL);
	assign ret     = cmd.resolve && hit && (e_kind == btp_pkg::KIND_RETURN);
	assign same    = (top_addr == pc4);
	assign pop_ok  = (top_cnt != '0);
	assign cnt_inc = (top_cnt == '1) ? top_cnt : top_cnt + 1'b1;
	assign cix     = hist_rdata ^ item_q.pc[IW-1:0];

	assign sts.clr_last = (clr_q == CW'(MAXD - 1));
	assign sts.need_ind = hit && (e_kind == btp_pkg::KIND_INDIRECT);

	// Write ports: clearing sweep wins, otherwise the resolve step writes.
	always_comb begin
		btb_we     = cmd.clear || (cmd.resolve && is_upd);
		btb_waddr  = cmd.clear ? clr_q[BI-1:0] : item_q.pc[TAG_BITS +: BI];
		btb_wdata  = cmd.clear ? '0 : {1'b1, item_q.pc[TAG_BITS-1:0],
			item_q.actual_target, item_q.branch_kind};
		hist_we    = cmd.clear || (cmd.resolve && upd_ind);
		hist_waddr = cmd.clear ? clr_q[HI-1:0] : item_q.pc[HI-1:0];
		hist_wdata = cmd.clear ? '0 : {hist_rdata[IW-2:0], item_q.taken};
		ind_we     = hist_we;
		ind_waddr  = cmd.clear ? clr_q[IW-1:0] : cix;
		ind_wdata  = cmd.clear ? '0 : item_q.actual_target;
		stk_we     = cmd.clear || call || (ret && pop_ok);
		stk_waddr  = cmd.clear ? clr_q[SW-1:0] : ((call && !same) ? sp_q + 1'b1 : sp_q);
		if (cmd.clear)         stk_wdata = '0;
		else if (call && same) stk_wdata = {top_addr, cnt_inc};
		else if (call)         stk_wdata = {pc4, REPEAT_BITS'(1)};
		else                   stk_wdata = {top_addr, top_cnt - 1'b1};
	end

	btp_ram #(.WIDTH(BW), .DEPTH(BTB_ENTRIES)) u_btb (
		.clk(clk), .we(btb_we), .waddr(btb_waddr), .wdata(btb_wdata),
		.re(cmd.capture), .raddr(item.pc[TAG_BITS +: BI]), .rdata(btb_rdata));
	btp_ram #(.WIDTH(KW), .DEPTH(STACK_DEPTH)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(cmd.capture), .raddr(sp_q), .rdata(stk_rdata));
	btp_ram #(.WIDTH(IW), .DEPTH(HISTORY_ENTRIES)) u_hist (
		.clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
		.re(cmd.capture), .raddr(item.pc[HI-1:0]), .rdata(hist_rdata));
	btp_ram #(.WIDTH(32), .DEPTH(INDIRECT_ENTRIES)) u_ind (
		.clk(clk), .we(ind_we), .waddr(ind_waddr), .wdata(ind_wdata),
		.re(cmd.resolve), .raddr(cix), .rdata(ind_rdata));

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
		if (cmd.resolve) begin
			if (call || (hit && e_kind == btp_pkg::KIND_DIRECT)) begin
				result_q.target_valid <= 1'b1;
				result_q.target       <= e_target;
			end else if (ret && pop_ok) begin
				result_q.target_valid <= 1'b1;
				result_q.target       <= top_addr;
			end else begin
				result_q.target_valid <= 1'b0;
				result_q.target       <= btp_pkg::NO_TARGET;
			end
		end else if (cmd.ind_done) begin
			result_q.target_valid <= 1'b1;
			result_q.target       <= ind_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q          <= '0;
			sp_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (call && !same)                  sp_q <= sp_q + 1'b1;
			else if (ret && top_cnt == REPEAT_BITS'(1)) sp_q <= sp_q - 1'b1;
			result_valid_q <= (cmd.resolve && !sts.need_ind) || cmd.ind_done;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;
endmodule
`default_nettype wire

// File: sim/branch_target_predictor_ras_tc_top_tb.sv
// Testbench: branch target predictor checked item by item against a behavioral predictor.
`default_nettype none
module branch_target_predictor_ras_tc_top_tb;
	localparam int unsigned N_BTB   = btp_pkg::BTB_ENTRIES_DEF;
	localparam int unsigned N_TAG   = btp_pkg::TAG_BITS_DEF;
	localparam int unsigned N_STACK = btp_pkg::STACK_DEPTH_DEF;
	localparam int unsigned N_HIST  = btp_pkg::HISTORY_ENTRIES_DEF;
	localparam int unsigned N_IND   = btp_pkg::INDIRECT_ENTRIES_DEF;
	localparam int unsigned N_RPT   = btp_pkg::REPEAT_BITS_DEF;
	localparam logic [N_RPT-1:0] REPEAT_TOP = '1;
	localparam int unsigned N_RANDOM = 1164;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam btp_pkg::result_t NO_RESULT = '{1'b0, btp_pkg::NO_TARGET};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	btp_pkg::item_t   item = '0;
	logic             busy;
	btp_pkg::result_t result;
	logic             result_valid;

	branch_target_predictor_ras_tc_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .result(result), .result_valid(result_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the predictor tables.
	logic                       btb_live [N_BTB];
	logic [N_TAG-1:0]           btb_tag [N_BTB];
	logic [31:0]                btb_target [N_BTB];
	logic [1:0]                 btb_kind [N_BTB];
	logic [31:0]                ras_addr [N_STACK];
	logic [N_RPT-1:0]           ras_count [N_STACK];
	logic [$clog2(N_STACK)-1:0] ras_top;
	logic [15:0]                hist_word [N_HIST];
	logic [31:0]                ind_target [N_IND];

	btp_pkg::result_t target_queue [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned send_idle_pct = 0;

	function automatic int unsigned ind_slot(logic [31:0] pc);
		return ((32'(hist_word[pc % N_HIST])) ^ pc) % N_IND;
	endfunction

	// Advance the shadow state by one item and return the predicted result.
	function automatic btp_pkg::result_t predict_target(btp_pkg::item_t it);
		btp_pkg::result_t r;
		int unsigned idx;
		int unsigned hi;
		logic [31:0] ret;
		r = NO_RESULT;
		idx = (it.pc >> N_TAG) % N_BTB;
		if (it.mode == btp_pkg::MODE_UPDATE) begin
			btb_live[idx] = 1'b1;
			btb_tag[idx] = it.pc[N_TAG-1:0];
			btb_target[idx] = it.actual_target;
			btb_kind[idx] = it.branch_kind;
			if (it.branch_kind == btp_pkg::KIND_INDIRECT) begin
				hi = it.pc % N_HIST;
				ind_target[ind_slot(it.pc)] = it.actual_target;
				hist_word[hi] = {hist_word[hi][14:0], it.taken};
			end
		end else if (btb_live[idx] && btb_tag[idx] == it.pc[N_TAG-1:0]) begin
			case (btb_kind[idx])
				btp_pkg::KIND_DIRECT: begin
					r = '{1'b1, btb_target[idx]};
				end
				btp_pkg::KIND_CALL: begin
					ret = it.pc + btp_pkg::PC_STEP;
					// Repeat of the top address bumps its count instead of pushing.
					if (ras_addr[ras_top] == ret) begin
						if (ras_count[ras_top] != REPEAT_TOP)
							ras_count[ras_top]++;
					end else begin
						ras_top++;
						ras_addr[ras_top] = ret;
						ras_count[ras_top] = N_RPT'(1);
					end
					r = '{1'b1, btb_target[idx]};
				end
				btp_pkg::KIND_RETURN: begin
					// Empty top gives no target and leaves the stack alone.
					if (ras_count[ras_top] != '0) begin
						r = '{1'b1, ras_addr[ras_top]};
						ras_count[ras_top]--;
						if (ras_count[ras_top] == '0)
							ras_top--;
					end
				end
				default: begin
					r = '{1'b1, ind_target[ind_slot(it.pc)]};
				end
			endcase
		end
		return r;
	endfunction

	// Drive one item: drop start while idling, then hold it until the item is taken.
	task automatic drive_item(btp_pkg::item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic send_item(btp_pkg::item_t it);
		target_queue.push_back(predict_target(it));
		drive_item(it);
	endtask

	// Check every result strobe against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (target_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h/%h", result.target_valid, result.target);
			end else begin
				btp_pkg::result_t want;
				want = target_queue.pop_front();
				if (want.target_valid !== result.target_valid ||
						want.target !== result.target) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result: expected %b/%h actual %b/%h", want.target_valid,
							want.target, result.target_valid, result.target);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("branch_target_predictor_ras_tc_top: mismatch");
			$finish;
		end
	end

	function automatic btp_pkg::item_t mk(logic m, logic [31:0] pc, logic [31:0] tgt,
			logic [1:0] k, logic tk);
		btp_pkg::item_t it;
		it.mode = m;
		it.pc = pc;
		it.actual_target = tgt;
		it.branch_kind = k;
		it.taken = tk;
		return it;
	endfunction

	// Random item, mostly drawn from a small pool of pcs so hits, calls and returns recur.
	function automatic btp_pkg::item_t rand_item();
		logic [31:0] pc;
		logic [1:0] k;
		k = 2'($urandom_range(3));
		if ($urandom_range(9) == 0)
			pc = $urandom();
		else
			pc = {$urandom_range(1, 0) ? 20'hFFFFF : 20'h00000,
				4'($urandom_range(7)), 8'($urandom_range(3) * 85)};
		return mk($urandom_range(2) == 0, pc, $urandom(), k, 1'($urandom_range(1)));
	endfunction

	typedef struct {
		btp_pkg::item_t   it;
		logic             typed;
		btp_pkg::result_t want;
	} stim_row_t;

	stim_row_t directed [$];

	initial begin
		btp_pkg::result_t got;
		for (int i = 0; i < N_BTB; i++) btb_live[i] = 1'b0;
		for (int i = 0; i < N_STACK; i++) begin
			ras_addr[i] = '0;
			ras_count[i] = '0;
		end
		for (int i = 0; i < N_HIST; i++) hist_word[i] = '0;
		for (int i = 0; i < N_IND; i++) ind_target[i] = '0;
		ras_top = '0;

		// Table: miss after reset, update result, every kind, extremes, stack edges.
		directed = '{
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_0000, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b1, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'hFFFF_FFFF, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b1, NO_RESULT},
			'{mk(btp_pkg::MODE_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, btp_pkg::KIND_DIRECT,
				1'b1), 1'b1, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'hFFFF_FFFF, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b1, '{1'b1, 32'hFFFF_FFFF}},
			'{mk(btp_pkg::MODE_PREDICT, 32'hFFFF_FFFE, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b1, NO_RESULT},
			'{mk(btp_pkg::MODE_UPDATE, 32'h0000_0000, 32'h0000_0000, btp_pkg::KIND_DIRECT,
				1'b0), 1'b1, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_0000, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b1, '{1'b1, 32'h0}},
			'{mk(btp_pkg::MODE_UPDATE, 32'h0000_1210, 32'h0000_1000, btp_pkg::KIND_RETURN,
				1'b0), 1'b0, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_1210, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b1, NO_RESULT},
			'{mk(btp_pkg::MODE_UPDATE, 32'h0000_0510, 32'h0000_2000, btp_pkg::KIND_CALL,
				1'b0), 1'b0, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_0510, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b1, '{1'b1, 32'h2000}},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_0510, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b0, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_0510, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b0, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_1210, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b1, '{1'b1, 32'h0514}},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_1210, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b0, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_1210, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b0, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_1210, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b1, NO_RESULT},
			'{mk(btp_pkg::MODE_UPDATE, 32'h0000_0733, 32'hABCD_0000, btp_pkg::KIND_INDIRECT,
				1'b1), 1'b0, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_0733, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b0, NO_RESULT},
			'{mk(btp_pkg::MODE_UPDATE, 32'h0000_0733, 32'h1234_5678, btp_pkg::KIND_INDIRECT,
				1'b0), 1'b0, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_0733, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b0, NO_RESULT},
			'{mk(btp_pkg::MODE_UPDATE, 32'h0000_0900, 32'h0000_0900, btp_pkg::KIND_RETURN,
				1'b1), 1'b0, NO_RESULT},
			'{mk(btp_pkg::MODE_PREDICT, 32'h0000_0900, 32'h0, btp_pkg::KIND_DIRECT, 1'b0),
				1'b1, NO_RESULT}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].typed) begin
				got = predict_target(directed[i].it);
				if (got != directed[i].want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("table row %0d: predictor %b/%h vs typed %b/%h", i,
							got.target_valid, got.target, directed[i].want.target_valid,
							directed[i].want.target);
				end
				// Expect the typed value; the predictor has already advanced its state.
				target_queue.push_back(directed[i].want);
				drive_item(directed[i].it);
			end else begin
				send_item(directed[i].it);
			end
		end

		// Saturate a repeat count: a long run of calls from one site.
		send_item(mk(btp_pkg::MODE_UPDATE, 32'h0000_0A40, 32'h0000_4000,
			btp_pkg::KIND_CALL, 1'b0));
		for (int i = 0; i < 260; i++)
			send_item(mk(btp_pkg::MODE_PREDICT, 32'h0000_0A40, 32'h0,
				btp_pkg::KIND_DIRECT, 1'b0));

		// Random phases: no idling, sender idle in 86 of 100, in 14 of 100, none again.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: send_idle_pct = 0;
				1: send_idle_pct = 86;
				2: send_idle_pct = 14;
				default: send_idle_pct = 0;
			endcase
			for (int i = 0; i < N_RANDOM / 4; i++)
				send_item(rand_item());
		end
		start <= 1'b0;

		while (target_queue.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("branch_target_predictor_ras_tc_top: match");
		else
			$display("branch_target_predictor_ras_tc_top: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
